FILE: sv/rtc3w_pkg.sv
package rtc3w_pkg;

  localparam int unsigned BURST_BYTES = 8;

  localparam logic [2:0] FN_TICK   = 3'd0;
  localparam logic [2:0] FN_SWRITE = 3'd1;
  localparam logic [2:0] FN_SREAD  = 3'd2;
  localparam logic [2:0] FN_BWRITE = 3'd3;
  localparam logic [2:0] FN_BREAD  = 3'd4;

  localparam logic [7:0] BURST_COMMAND_RESET = 8'd190;
  localparam logic       REG_BURST_COMMAND   = 1'b0;

  typedef struct packed {
    logic [2:0]  func;
    logic [7:0]  address;
    logic [7:0]  write_data;
    logic [63:0] burst_data;
    logic        io_in;
  } item_t;

  typedef struct packed {
    logic        chip_enable;
    logic        serial_clock;
    logic        io_out;
    logic        io_drive;
    logic        busy_res;
    logic        done_res;
    logic [63:0] read_result;
  } result_t;

endpackage

FILE: sv/rtc3w_cfg.sv
module rtc3w_cfg
  import rtc3w_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output logic [7:0]  burst_command
);

  logic wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite && (paddr[2] == REG_BURST_COMMAND);

  always_ff @(posedge clk) begin
    if (rst) begin
      burst_command <= BURST_COMMAND_RESET;
    end else if (wr_en) begin
      burst_command <= pwdata[7:0];
    end
  end

  assign prdata = (paddr[2] == REG_BURST_COMMAND) ? {24'd0, burst_command} : 32'd0;

endmodule

FILE: sv/rtc3w_core.sv
module rtc3w_core
  import rtc3w_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       step,
  input  item_t      item,
  input  logic [7:0] burst_command,
  output result_t    res
);

  typedef enum logic [2:0] {
    PH_IDLE    = 3'd0,
    PH_SEND_LO = 3'd1,
    PH_SEND_HI = 3'd2,
    PH_GAP     = 3'd3,
    PH_READ_LO = 3'd4,
    PH_READ_HI = 3'd5,
    PH_END     = 3'd6
  } phase_t;

  phase_t      phase, phase_next;
  logic [1:0]  operation, operation_next;
  logic [2:0]  bit_position, bit_position_next;
  logic [3:0]  byte_position, byte_position_next;
  logic [7:0]  command_shift, command_shift_next;
  logic [63:0] transmit_bytes, transmit_bytes_next;
  logic [63:0] receive_bytes, receive_bytes_next;
  logic        line_ce, line_clk, line_io, line_drive;
  logic        line_ce_next, line_clk_next, line_io_next, line_drive_next;
  logic        done;

  logic       busy;
  logic [3:0] n_bytes;
  logic [3:0] byte_m1;
  logic [3:0] byte_incr;
  logic [5:0] bit_idx;
  logic       send_bit;
  logic [1:0] start_op;
  logic [7:0] start_cmd;

  assign busy      = (phase != PH_IDLE);
  // burst transactions carry the full burst, single ones a byte
  assign n_bytes   = operation[1] ? 4'(BURST_BYTES) : 4'd1;
  assign byte_m1   = byte_position - 4'd1;
  assign byte_incr = byte_position + 4'd1;
  assign bit_idx   = {byte_m1[2:0], bit_position};
  assign send_bit  = (byte_position == 4'd0) ? command_shift[bit_position]
                                             : transmit_bytes[bit_idx];
  assign start_op  = 2'(item.func - 3'd1);
  assign start_cmd = start_op[1] ? burst_command : item.address;

  always_comb begin
    phase_next          = phase;
    operation_next      = operation;
    bit_position_next   = bit_position;
    byte_position_next  = byte_position;
    command_shift_next  = command_shift;
    transmit_bytes_next = transmit_bytes;
    receive_bytes_next  = receive_bytes;
    line_ce_next        = line_ce;
    line_clk_next       = line_clk;
    line_io_next        = line_io;
    line_drive_next     = line_drive;
    done                = 1'b0;

    if (item.func >= FN_SWRITE && item.func <= FN_BREAD) begin
      if (!busy) begin
        operation_next      = start_op;
        command_shift_next  = start_cmd | {7'd0, start_op[0]};
        if (start_op[0]) begin
          transmit_bytes_next = 64'd0;
        end else if (start_op[1]) begin
          transmit_bytes_next = item.burst_data;
        end else begin
          transmit_bytes_next = {56'd0, item.write_data};
        end
        receive_bytes_next  = 64'd0;
        bit_position_next   = 3'd0;
        byte_position_next  = 4'd0;
        phase_next          = PH_SEND_LO;
        line_ce_next        = 1'b1;
        line_clk_next       = 1'b0;
        line_io_next        = 1'b0;
        line_drive_next     = 1'b1;
      end
    end else if (item.func == FN_TICK) begin
      case (phase)
        PH_IDLE: begin
          phase_next = PH_IDLE;
        end
        PH_SEND_LO: begin
          line_ce_next    = 1'b1;
          line_clk_next   = 1'b0;
          line_io_next    = send_bit;
          line_drive_next = 1'b1;
          phase_next      = PH_SEND_HI;
        end
        PH_SEND_HI: begin
          line_ce_next    = 1'b1;
          line_clk_next   = 1'b1;
          line_io_next    = send_bit;
          line_drive_next = 1'b1;
          if (bit_position == 3'd7) begin
            bit_position_next = 3'd0;
            phase_next        = PH_GAP;
          end else begin
            bit_position_next = bit_position + 3'd1;
            phase_next        = PH_SEND_LO;
          end
        end
        PH_GAP: begin
          line_ce_next       = 1'b1;
          line_clk_next      = 1'b0;
          line_io_next       = 1'b1;
          line_drive_next    = 1'b1;
          byte_position_next = byte_incr;
          if (operation[0]) begin
            phase_next = PH_READ_LO;
          end else if (byte_incr > n_bytes) begin
            phase_next = PH_END;
          end else begin
            phase_next = PH_SEND_LO;
          end
        end
        PH_READ_LO: begin
          line_ce_next    = 1'b1;
          line_clk_next   = 1'b0;
          line_io_next    = 1'b0;
          line_drive_next = 1'b0;
          // sample before the clock rise; the command byte slot is not stored
          if (byte_position != 4'd0 && item.io_in) begin
            receive_bytes_next = receive_bytes | (64'd1 << bit_idx);
          end
          phase_next = PH_READ_HI;
        end
        PH_READ_HI: begin
          line_ce_next    = 1'b1;
          line_clk_next   = 1'b1;
          line_io_next    = 1'b0;
          line_drive_next = 1'b0;
          if (bit_position == 3'd7) begin
            bit_position_next  = 3'd0;
            byte_position_next = byte_incr;
            phase_next         = (byte_incr > n_bytes) ? PH_END : PH_READ_LO;
          end else begin
            bit_position_next = bit_position + 3'd1;
            phase_next        = PH_READ_LO;
          end
        end
        PH_END: begin
          line_ce_next    = 1'b0;
          line_clk_next   = 1'b0;
          line_io_next    = 1'b0;
          line_drive_next = 1'b0;
          done            = 1'b1;
          phase_next      = PH_IDLE;
        end
        default: begin
          phase_next = PH_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase          <= PH_IDLE;
      operation      <= 2'd0;
      bit_position   <= 3'd0;
      byte_position  <= 4'd0;
      command_shift  <= 8'd0;
      transmit_bytes <= 64'd0;
      receive_bytes  <= 64'd0;
      line_ce        <= 1'b0;
      line_clk       <= 1'b0;
      line_io        <= 1'b0;
      line_drive     <= 1'b0;
    end else if (step) begin
      phase          <= phase_next;
      operation      <= operation_next;
      bit_position   <= bit_position_next;
      byte_position  <= byte_position_next;
      command_shift  <= command_shift_next;
      transmit_bytes <= transmit_bytes_next;
      receive_bytes  <= receive_bytes_next;
      line_ce        <= line_ce_next;
      line_clk       <= line_clk_next;
      line_io        <= line_io_next;
      line_drive     <= line_drive_next;
    end
  end

  assign res.chip_enable  = line_ce_next;
  assign res.serial_clock = line_clk_next;
  assign res.io_out       = line_io_next;
  assign res.io_drive     = line_drive_next;
  assign res.busy_res     = (phase_next != PH_IDLE);
  assign res.done_res     = done;
  assign res.read_result  = receive_bytes_next;

`ifndef SYNTHESIS
  a_ce_tracks_busy: assert property (@(posedge clk) disable iff (rst)
    line_ce == busy)
    else $error("chip enable out of step with transaction phase");

  a_gap_bit_zero: assert property (@(posedge clk) disable iff (rst)
    phase == PH_GAP |-> bit_position == 3'd0)
    else $error("bit counter not cleared at byte gap");

  a_byte_bound: assert property (@(posedge clk) disable iff (rst)
    byte_position <= 4'(BURST_BYTES + 1))
    else $error("byte counter past end of burst");

  a_read_released: assert property (@(posedge clk) disable iff (rst)
    phase == PH_READ_HI |-> !line_drive)
    else $error("data line driven during read");
`endif

endmodule

FILE: sv/three_wire_rtc_bus_master_top.sv
// Master for a three-wire clock-chip bus (chip enable, serial clock, data line with
// separate drive enable). Each input word is either a start (single or burst read/write)
// or a tick that moves the transaction by half a serial clock bit; every accepted word
// yields exactly one result word carrying the line levels, busy, done and the receive
// register. Throughput is one word per clock: the word passes an input register, the
// transaction state is updated in a single pass of logic, and the result lands in an
// output register; only m_tready backpressure stalls the stream. There is no clearing
// pass after reset. burst_command sits at APB address 0.
module three_wire_rtc_bus_master_top
  import rtc3w_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [87:0] s_tdata,   // address, write_data, burst_data, io_in, zero pad
  input  logic [2:0]  s_tuser,   // func
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [71:0] m_tdata,   // chip_enable, serial_clock, io_out, io_drive, busy_res,
                                 // done_res, read_result, zero pad
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic       in_valid;
  item_t      in_item;
  logic       out_valid;
  result_t    out_res;
  result_t    core_res;
  logic       en_out;
  logic       en_in;
  logic       step;
  logic [7:0] burst_command;

  assign en_out   = !out_valid || m_tready;
  assign en_in    = !in_valid || en_out;
  assign step     = en_out && in_valid;
  assign s_tready = en_in;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (en_out) out_valid <= in_valid;
      if (en_in)  in_valid  <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (en_in && s_tvalid) begin
      in_item.func       <= s_tuser;
      in_item.address    <= s_tdata[7:0];
      in_item.write_data <= s_tdata[15:8];
      in_item.burst_data <= s_tdata[79:16];
      in_item.io_in      <= s_tdata[80];
    end
    if (step) begin
      out_res <= core_res;
    end
  end

  rtc3w_cfg u_cfg (
    .clk           (clk),
    .rst           (rst),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready),
    .burst_command (burst_command)
  );

  rtc3w_core u_core (
    .clk           (clk),
    .rst           (rst),
    .step          (step),
    .item          (in_item),
    .burst_command (burst_command),
    .res           (core_res)
  );

  assign m_tvalid = out_valid;
  assign m_tdata  = {2'b00, out_res.read_result, out_res.done_res, out_res.busy_res,
                     out_res.io_drive, out_res.io_out, out_res.serial_clock,
                     out_res.chip_enable};

endmodule
